// ===== sv/bsc_pkg.sv =====
// bsc_pkg: constants, types and GF(2^m) helpers for the BCH syndrome block
// no dependencies; imported by every other file of the block
package bsc_pkg;

	localparam int MAX_M     = 8;
	localparam int MAX_T     = 8;
	localparam int LANES     = 2 * MAX_T;
	localparam int LANE_W    = $clog2(LANES);
	localparam int NUM_W     = $clog2(LANES + 1);
	localparam int DEG_W     = $clog2(MAX_M + 1);
	localparam int LEN_W     = 8;
	localparam int T_W       = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;

	typedef logic [MAX_M-1:0] gf_t;
	typedef logic [MAX_M:0]   gf_poly_t;
	typedef logic [DEG_W-1:0] gf_deg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_LENGTH = 1'b0,
		REG_CORRECT_T   = 1'b1
	} cfg_reg_t;

	// control from the top level to the lane array
	typedef struct packed {
		logic clear;    // return the word state to reset
		logic restart;  // recompute the per-lane constants
		logic step;     // counted bit this cycle
		logic data_bit;
	} lane_ctrl_t;

	// smallest m with 2^m-1 >= n, capped at MAX_M
	function automatic gf_deg_t field_degree(input logic [LEN_W-1:0] n);
		gf_deg_t m;
		m = gf_deg_t'(MAX_M);
		for (int k = MAX_M; k >= 1; k--) begin
			if (((LEN_W+1)'(1) << k) - (LEN_W+1)'(1) >= {1'b0, n})
				m = gf_deg_t'(k);
		end
		return m;
	endfunction

	function automatic gf_poly_t field_poly(input gf_deg_t m);
		gf_poly_t p;
		case (m)
			gf_deg_t'(3): p = gf_poly_t'(9'h00B);
			gf_deg_t'(4): p = gf_poly_t'(9'h013);
			gf_deg_t'(5): p = gf_poly_t'(9'h025);
			gf_deg_t'(6): p = gf_poly_t'(9'h043);
			gf_deg_t'(7): p = gf_poly_t'(9'h083);
			gf_deg_t'(8): p = gf_poly_t'(9'h11D);
			default:      p = (gf_poly_t'(1) << m) | gf_poly_t'(3);
		endcase
		return p;
	endfunction

	function automatic gf_t gf_mask(input gf_deg_t m);
		gf_t k;
		for (int b = 0; b < MAX_M; b++)
			k[b] = (b < int'(m));
		return k;
	endfunction

	// multiply by alpha
	function automatic gf_t gf_xtime(input gf_t a, input gf_deg_t m, input gf_poly_t poly);
		gf_poly_t w;
		w = {a, 1'b0};
		if (w[m])
			w = w ^ poly;
		return w[MAX_M-1:0] & gf_mask(m);
	endfunction

	// full multiply, msb first shift and add
	function automatic gf_t gf_mul(input gf_t x, input gf_t c, input gf_deg_t m,
		input gf_poly_t poly);
		gf_t acc;
		acc = '0;
		for (int b = MAX_M - 1; b >= 0; b--)
			acc = gf_xtime(acc, m, poly) ^ (c[b] ? x : gf_t'(0));
		return acc;
	endfunction

endpackage

// ===== sv/bsc_if.sv =====
// bsc_if: valid/ready channels for received bits and syndrome words
// depends on bsc_pkg
interface bsc_bit_if;
	logic valid;
	logic ready;
	logic received_bit;
	logic end_of_word;

	modport source(output valid, output received_bit, output end_of_word, input ready);
	modport sink(input valid, input received_bit, input end_of_word, output ready);
endinterface

interface bsc_syn_if;
	import bsc_pkg::*;
	logic             valid;
	logic             ready;
	logic [MAX_M-1:0] syndrome_value;
	logic [NUM_W-1:0] syndrome_number;
	logic             last_syndrome;

	modport source(output valid, output syndrome_value, output syndrome_number,
		output last_syndrome, input ready);
	modport sink(input valid, input syndrome_value, input syndrome_number,
		input last_syndrome, output ready);
endinterface

// ===== sv/bsc_lanes.sv =====
// bsc_lanes: one accumulator and running power per syndrome lane, plus the
// sweep that builds the lane constants alpha^i; depends on bsc_pkg
module bsc_lanes (
	input  logic                clk,
	input  logic                arst_n,
	input  bsc_pkg::lane_ctrl_t ctrl,
	input  bsc_pkg::gf_deg_t    field_m,
	input  bsc_pkg::gf_poly_t   field_p,
	output logic                consts_ready,
	output bsc_pkg::gf_t        acc_next [bsc_pkg::LANES]
);
	import bsc_pkg::*;

	gf_t               acc_q   [LANES];
	gf_t               pow_q   [LANES];
	gf_t               const_q [LANES];
	gf_t               sweep_pow_q;
	logic [LANE_W-1:0] sweep_idx_q;
	logic              sweep_busy_q;
	gf_t               sweep_pow_next;

	assign consts_ready   = !sweep_busy_q;
	assign sweep_pow_next = gf_xtime(sweep_pow_q, field_m, field_p);

	// one lane constant per cycle after reset or a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_busy_q <= 1'b1;
			sweep_idx_q  <= '0;
			sweep_pow_q  <= gf_t'(1);
		end else if (ctrl.restart) begin
			sweep_busy_q <= 1'b1;
			sweep_idx_q  <= '0;
			sweep_pow_q  <= gf_t'(1);
		end else if (sweep_busy_q) begin
			sweep_pow_q  <= sweep_pow_next;
			sweep_idx_q  <= sweep_idx_q + LANE_W'(1);
			if (sweep_idx_q == LANE_W'(LANES - 1))
				sweep_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_busy_q && !ctrl.restart)
			const_q[sweep_idx_q] <= sweep_pow_next;
	end

	always_comb begin
		for (int i = 0; i < LANES; i++)
			acc_next[i] = (ctrl.step && ctrl.data_bit) ? (acc_q[i] ^ pow_q[i]) : acc_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= '0;
				pow_q[i] <= gf_t'(1);
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= '0;
				pow_q[i] <= gf_t'(1);
			end
		end else if (ctrl.step) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= acc_next[i];
				pow_q[i] <= gf_mul(pow_q[i], const_q[i], field_m, field_p);
			end
		end
	end

endmodule

// ===== sv/bch_syndrome_calculator_unit.sv =====
// bch_syndrome_calculator_unit: serial syndrome calculator for binary BCH codes
// depends on bsc_pkg, bsc_if and bsc_lanes
//
//   port        dir   handshake      word
//   rx_bits     in    valid/ready    received_bit, end_of_word
//   syndromes   out   valid/ready    syndrome_value, syndrome_number, last_syndrome
//   cfg_*       in    write enable   cfg_index, cfg_data
//
// one received bit per cycle while rx_bits.ready is high; every lane multiplies
// its running power by its constant in the same cycle. at end of word the 2t
// syndromes go to an output buffer and leave one per cycle while syndromes.ready
// is high, as the next word's bits are taken in. an end-of-word bit also waits
// while the buffer holds syndromes, unless the last one goes out that cycle. no bit
// is accepted while the lane constants rebuild after reset and each register write.
module bch_syndrome_calculator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	bsc_bit_if.sink                     rx_bits,
	bsc_syn_if.source                   syndromes,
	input  logic                        cfg_we,
	input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsc_pkg::CFG_W-1:0]   cfg_data
);
	import bsc_pkg::*;

	logic [LEN_W-1:0] code_length_q;
	logic [T_W-1:0]   correct_t_q;
	logic [LEN_W-1:0] pos_q;
	gf_deg_t          field_m;
	gf_poly_t         field_p;
	lane_ctrl_t       ctrl;
	logic             consts_ready;
	gf_t              acc_next [LANES];
	logic             cfg_hit;
	logic             in_accept;
	logic             out_accept;
	logic             out_last;
	logic [NUM_W-1:0] word_count;
	logic [T_W-1:0]   t_eff;

	gf_t              snap_q [LANES];
	logic [LANE_W-1:0] out_idx_q;
	logic [NUM_W-1:0] out_count_q;
	logic             out_valid_q;

	assign field_m = field_degree(code_length_q);
	assign field_p = field_poly(field_m);

	assign cfg_hit = cfg_we && (cfg_index == REG_CODE_LENGTH || cfg_index == REG_CORRECT_T);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= LEN_W'(255);
			correct_t_q   <= T_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CODE_LENGTH: code_length_q <= cfg_data[LEN_W-1:0];
				REG_CORRECT_T:   correct_t_q   <= cfg_data[T_W-1:0];
				default: ;
			endcase
		end
	end

	// number of syndromes per word
	always_comb begin
		t_eff = (correct_t_q > T_W'(MAX_T)) ? T_W'(MAX_T) : correct_t_q;
		if (code_length_q == '0)
			word_count = '0;
		else
			word_count = NUM_W'({t_eff, 1'b0});
	end

	assign out_last   = (NUM_W'(out_idx_q) + NUM_W'(1)) == out_count_q;
	assign out_accept = out_valid_q && syndromes.ready;

	assign rx_bits.ready = consts_ready
		&& (!rx_bits.end_of_word || !out_valid_q || (syndromes.ready && out_last));
	assign in_accept = rx_bits.valid && rx_bits.ready;

	always_comb begin
		ctrl.restart  = cfg_hit;
		ctrl.clear    = cfg_hit || (in_accept && rx_bits.end_of_word);
		ctrl.step     = in_accept && (pos_q < code_length_q);
		ctrl.data_bit = rx_bits.received_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (ctrl.clear)
			pos_q <= '0;
		else if (in_accept && pos_q != '1)
			pos_q <= pos_q + LEN_W'(1);
	end

	bsc_lanes u_lanes (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.field_m      (field_m),
		.field_p      (field_p),
		.consts_ready (consts_ready),
		.acc_next     (acc_next)
	);

	// output buffer: syndromes shift toward slot 0 as they are taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_count_q <= '0;
		end else if (in_accept && rx_bits.end_of_word && word_count != '0) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
			out_count_q <= word_count;
		end else if (out_accept) begin
			out_idx_q <= out_idx_q + LANE_W'(1);
			if (out_last)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && rx_bits.end_of_word) begin
			for (int i = 0; i < LANES; i++)
				snap_q[i] <= acc_next[i];
		end else if (out_accept) begin
			for (int i = 0; i < LANES - 1; i++)
				snap_q[i] <= snap_q[i+1];
			snap_q[LANES-1] <= '0;
		end
	end

	assign syndromes.valid           = out_valid_q;
	assign syndromes.syndrome_value  = snap_q[0];
	assign syndromes.syndrome_number = NUM_W'(out_idx_q) + NUM_W'(1);
	assign syndromes.last_syndrome   = out_last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for bch_syndrome_calculator_unit, bits in and syndromes out
// depends on bsc_pkg, bsc_if and the block; models each syndrome unless a row types it
module tb;
	import bsc_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 8;
	localparam int IDLE_PCT       = 18;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 24;
	localparam int STALL_LIMIT    = 1000;
	localparam int RANDOM_ITEMS   = 90;
	localparam int N_DIRECTED     = 29;

	typedef enum logic {
		ROW_BIT,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_reg_t         reg_sel;
		logic [CFG_W-1:0] reg_value;
		logic             data_bit;
		logic             word_end;
		logic             typed;
		gf_t              typed_syndrome;
	} stim_row_t;

	typedef struct packed {
		gf_t              value;
		logic [NUM_W-1:0] number;
		logic             last;
	} syndrome_word_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             steady;
	int               errors = 0;
	int               stall_cycles = 0;

	bsc_bit_if bits_ch();
	bsc_syn_if syn_ch();

	bch_syndrome_calculator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_bits   (bits_ch),
		.syndromes (syn_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// typed values: every syndrome of the word equals the given element
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b1, 8'h01}, // one set bit at position 0
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00}, // all-zero word
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, REG_CORRECT_T,   8'h08, 1'b0, 1'b0, 1'b0, 8'h00}, // all 16 lanes
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, REG_CORRECT_T,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00}, // t = 0, no syndromes
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, REG_CORRECT_T,   8'hFF, 1'b0, 1'b0, 1'b0, 8'h00}, // t = 15 clamps to 8
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b1, 8'h01},
		'{ROW_CFG, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}, // zero length
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, REG_CODE_LENGTH, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00}, // m = 1
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00}, // past the cutoff
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b1, 1'b1, 8'h01},
		'{ROW_CFG, REG_CODE_LENGTH, 8'h03, 1'b0, 1'b0, 1'b0, 8'h00}, // m = 2
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, REG_CODE_LENGTH, 8'h07, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, REG_CORRECT_T,   8'h01, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00}, // left open
		'{ROW_CFG, REG_CODE_LENGTH, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00}, // write drops it
		'{ROW_BIT, REG_CODE_LENGTH, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00}
	};

	logic [LEN_W-1:0] boundary_lengths [17] = '{
		8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd8, 8'd15, 8'd16,
		8'd31, 8'd32, 8'd63, 8'd64, 8'd127, 8'd128, 8'd254, 8'd255
	};

	// syndrome model state
	logic [LEN_W-1:0] cur_len;
	logic [T_W-1:0]   cur_t;
	logic [LEN_W-1:0] bit_pos;
	gf_t              lane_acc [LANES];
	gf_t              lane_pow [LANES];
	syndrome_word_t   expected_syndromes [$];
	syndrome_word_t   head;

	function automatic int degree_for(input logic [LEN_W-1:0] n);
		int m;
		m = 1;
		while (((1 << m) - 1) < int'(n) && m < MAX_M)
			m++;
		return m;
	endfunction

	function automatic int poly_for(input int m);
		case (m)
			3: return 'h00B;
			4: return 'h013;
			5: return 'h025;
			6: return 'h043;
			7: return 'h083;
			8: return 'h11D;
			default: return (1 << m) | 'h3;
		endcase
	endfunction

	// x * alpha^k, one shift and reduce per power
	function automatic gf_t times_alpha(input gf_t x, input int k, input int m, input int poly);
		int v;
		int mask;
		mask = (1 << m) - 1;
		v = int'(x) & mask;
		for (int s = 0; s < k; s++) begin
			v = v << 1;
			if ((v & (1 << m)) != 0)
				v = v ^ poly;
			v = v & mask;
		end
		return gf_t'(v);
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		if ($urandom_range(0, 1) == 0)
			return boundary_lengths[$urandom_range(0, 16)];
		return LEN_W'($urandom_range(0, 255));
	endfunction

	task automatic clear_word();
		for (int i = 0; i < LANES; i++) begin
			lane_acc[i] = '0;
			lane_pow[i] = gf_t'(1);
		end
		bit_pos = '0;
	endtask

	task automatic account_bit(input logic b, input logic e, input logic typed, input gf_t typed_val);
		int m;
		int poly;
		int t_eff;
		int count;
		syndrome_word_t w;
		m = degree_for(cur_len);
		poly = poly_for(m);
		if (bit_pos < cur_len) begin
			for (int i = 0; i < LANES; i++) begin
				if (b)
					lane_acc[i] ^= lane_pow[i];
				lane_pow[i] = times_alpha(lane_pow[i], i + 1, m, poly);
			end
		end
		if (bit_pos != '1)
			bit_pos++;
		if (e) begin
			t_eff = (int'(cur_t) > MAX_T) ? MAX_T : int'(cur_t);
			count = (cur_len == 0) ? 0 : 2 * t_eff;
			for (int i = 0; i < count; i++) begin
				w.value = typed ? typed_val : lane_acc[i];
				w.number = NUM_W'(i + 1);
				w.last = (i + 1 == count);
				expected_syndromes.push_back(w);
			end
			clear_word();
		end
	endtask

	// called and returns at a falling edge
	task automatic put_bit(input logic b, input logic e, input logic typed, input gf_t typed_val);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			bits_ch.valid <= 1'b0;
			@(negedge clk);
		end
		bits_ch.valid <= 1'b1;
		bits_ch.received_bit <= b;
		bits_ch.end_of_word <= e;
		do
			@(posedge clk);
		while (bits_ch.ready !== 1'b1);
		account_bit(b, e, typed, typed_val);
		@(negedge clk);
	endtask

	task automatic drain();
		bits_ch.valid <= 1'b0;
		while (expected_syndromes.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		case (sel)
			REG_CODE_LENGTH: cur_len = value;
			REG_CORRECT_T:   cur_t = value[T_W-1:0];
			default: ;
		endcase
		clear_word();
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic compare_field(input string what, input int idx, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: S%0d %s expected %0h got %0h", $time, idx, what, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		syn_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && syn_ch.valid === 1'b1 && syn_ch.ready) begin
			if (expected_syndromes.size() == 0) begin
				$display("%0t: unexpected word S%0d value %0h expected none", $time,
					syn_ch.syndrome_number, syn_ch.syndrome_value);
				errors++;
			end else begin
				head = expected_syndromes.pop_front();
				compare_field("value", int'(head.number), 8'(head.value),
					8'(syn_ch.syndrome_value));
				compare_field("number", int'(head.number), 8'(head.number),
					8'(syn_ch.syndrome_number));
				compare_field("last", int'(head.number), 8'(head.last),
					8'(syn_ch.last_syndrome));
			end
		end
	end

	// ends the run when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (bits_ch.valid && bits_ch.ready) || (syn_ch.valid && syn_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int random_items;
		int phase;
		int words;
		int len;
		int t_pick;
		logic e;
		logic broken;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CODE_LENGTH;
		cfg_data = '0;
		bits_ch.valid = 1'b0;
		bits_ch.received_bit = 1'b0;
		bits_ch.end_of_word = 1'b0;
		steady = 1'b0;
		cur_len = 8'd255;
		cur_t = 4'd2;
		clear_word();
		random_items = 0;
		phase = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				settle();
				write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_value);
			end else begin
				put_bit(directed_rows[r].data_bit, directed_rows[r].word_end,
					directed_rows[r].typed, directed_rows[r].typed_syndrome);
			end
		end

		// random words, a fresh setting per phase; the last word may be left open
		while (random_items < RANDOM_ITEMS) begin
			settle();
			steady = (phase == 0);
			write_reg(REG_CODE_LENGTH, pick_length());
			t_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			write_reg(REG_CORRECT_T, {4'($urandom), 4'(t_pick)});
			words = $urandom_range(2, 5);
			for (int w = 0; w < words && random_items < RANDOM_ITEMS; w++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				broken = (w == words - 1) && ($urandom_range(0, 3) == 0);
				for (int k = 0; k < len; k++) begin
					e = (k == len - 1) && !broken;
					random_items++;
					put_bit(1'($urandom), e, 1'b0, '0);
				end
				if (w != words - 1 && $urandom_range(0, 5) == 0)
					drain();
			end
			phase++;
		end

		steady = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
